[src/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int WordWidth    = 32;
  localparam int DefaultDepth = 256;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef logic signed [WordWidth-1:0] word_t;

  // push: every cell takes its upper neighbour; pop: its lower neighbour
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  localparam word_t NoneWord = '1;

endpackage

[src/mts_cell.sv]
// ----------------------------------------------------------------------------
// mts_cell
// One stack entry; shifts down on push, up on pop, else holds.
// ----------------------------------------------------------------------------
module mts_cell import mts_pkg::*; (
  input  logic   clk,
  input  shift_t shift,
  input  word_t  from_above,
  input  word_t  from_below,
  output word_t  q
);

  always_ff @(posedge clk) begin
    if (shift.push) begin
      q <= from_above;
    end else if (shift.pop) begin
      q <= from_below;
    end
  end

endmodule

[src/mts_chain.sv]
// ----------------------------------------------------------------------------
// mts_chain
// Row of stack cells; cell 0 is the top of the stack.
// ----------------------------------------------------------------------------
module mts_chain import mts_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic   clk,
  input  shift_t shift,
  input  word_t  push_word,
  output word_t  top,
  output word_t  second
);

  word_t q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t above;
    word_t below;

    if (i == 0) begin : g_first
      assign above = push_word;
    end else begin : g_inner_a
      assign above = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below = NoneWord;
    end else begin : g_inner_b
      assign below = q[i+1];
    end

    mts_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .q          (q[i])
    );
  end

  assign top    = q[0];
  assign second = q[1];

endmodule

[src/min_tracking_stack.sv]
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO of signed 32-bit words that reports its minimum after every transfer.
// ----------------------------------------------------------------------------
// Each input transfer (push, pop or query; code 3 acts as a query) yields one
// output transfer with the popped word, the new top, the new minimum and flags.
// Both stacks are rows of shifting cells with the top held in cell 0, so every
// operation completes with no busy state: one transfer per clock is sustained
// while the output is not stalled, and each result is registered on acceptance.
// Pushes to a full stack are dropped with overflow set; pops of an empty stack
// change nothing. Empty stacks report -1 for top and minimum.
module min_tracking_stack import mts_pkg::*; #(
  parameter int STACK_DEPTH = DefaultDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // value
  input  logic [1:0]   s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // popped_value, top_value, min_value
  output logic [2:0]   m_axis_tuser    // popped_valid, is_empty, overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(STACK_DEPTH);

  logic [CW-1:0] value_count, value_count_next;
  logic [CW-1:0] min_count, min_count_next;

  word_t  val_in;
  word_t  v_top, v_second, m_top, m_second;
  shift_t v_shift, m_shift;
  logic   acc, is_push, is_pop, full;
  word_t  popped_word, top_word, min_word;

  assign val_in        = word_t'(s_axis_tdata);
  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_push       = s_axis_tuser == OP_PUSH;
  assign is_pop        = s_axis_tuser == OP_POP;
  assign full          = value_count == FullCount;

  always_comb begin
    v_shift.push = acc && is_push && !full;
    v_shift.pop  = acc && is_pop && (value_count != '0);
    m_shift.push = v_shift.push &&
                   ((min_count == '0) || ((min_count != FullCount) && (val_in <= m_top)));
    m_shift.pop  = v_shift.pop && (min_count != '0) && (v_top == m_top);

    value_count_next = value_count;
    if (v_shift.push) begin
      value_count_next = value_count + CW'(1);
    end else if (v_shift.pop) begin
      value_count_next = value_count - CW'(1);
    end

    min_count_next = min_count;
    if (m_shift.push) begin
      min_count_next = min_count + CW'(1);
    end else if (m_shift.pop) begin
      min_count_next = min_count - CW'(1);
    end

    popped_word = v_shift.pop ? v_top : NoneWord;

    if (value_count_next == '0) begin
      top_word = NoneWord;
    end else if (v_shift.push) begin
      top_word = val_in;
    end else if (v_shift.pop) begin
      top_word = v_second;
    end else begin
      top_word = v_top;
    end

    if (min_count_next == '0) begin
      min_word = NoneWord;
    end else if (m_shift.push) begin
      min_word = val_in;
    end else if (m_shift.pop) begin
      min_word = m_second;
    end else begin
      min_word = m_top;
    end
  end

  mts_chain #(.DEPTH(STACK_DEPTH)) u_values (
    .clk       (clk),
    .shift     (v_shift),
    .push_word (val_in),
    .top       (v_top),
    .second    (v_second)
  );

  mts_chain #(.DEPTH(STACK_DEPTH)) u_mins (
    .clk       (clk),
    .shift     (m_shift),
    .push_word (val_in),
    .top       (m_top),
    .second    (m_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count   <= '0;
      min_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      value_count <= value_count_next;
      min_count   <= min_count_next;
      if (acc) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m_axis_tdata <= {min_word, top_word, popped_word};
      m_axis_tuser <= {acc && is_push && full, value_count_next == '0, v_shift.pop};
    end
  end

  a_min_le_count: assert property (@(posedge clk) disable iff (rst)
    min_count <= value_count)
    else $error("minimum stack deeper than value stack");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    value_count <= FullCount)
    else $error("value count beyond depth");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    acc && is_push && full |=> m_axis_tvalid && m_axis_tuser[2] && value_count == FullCount)
    else $error("push to full stack not flagged or not dropped");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    acc && is_pop && (value_count != '0) |=>
      value_count == $past(value_count) - CW'(1) && m_axis_tuser[0])
    else $error("pop did not remove an entry");

  a_min_nonempty: assert property (@(posedge clk) disable iff (rst)
    (value_count != '0) |-> (min_count != '0))
    else $error("minimum stack empty while values held");

endmodule
